// File: design/sdhs_pkg.sv
`default_nettype none

package sdhs_pkg;

	// Position word width (encoder angle, signed Q3.12 radians).
	localparam int unsigned POSITION_BITS = 16;
	localparam int unsigned DRIVE_BITS = 11;
	localparam int unsigned LEVEL_BITS = 10;
	localparam int unsigned CFG_DATA_BITS = 16;
	localparam int unsigned CFG_INDEX_BITS = 3;

	// Largest drive magnitude in permille.
	localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = LEVEL_BITS'(1000);

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_CHECK_INTERVAL = 3'd0,
		REG_POS_THRESHOLD  = 3'd1,
		REG_STALL_CHECKS   = 3'd2,
		REG_TRAVEL         = 3'd3,
		REG_DRIVE_LEVEL    = 3'd4
	} reg_index_t;

	// Event kinds carried by an input item.
	typedef enum logic [1:0] {
		MODE_TICK   = 2'd0,
		MODE_START  = 2'd1,
		MODE_CANCEL = 2'd2,
		MODE_NOP    = 2'd3
	} mode_t;

	// Sequencer phase.
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_EXTEND  = 2'd1,
		PH_RETRACT = 2'd2
	} phase_t;

	// Event result codes.
	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_FOUND  = 3'd1,
		EV_DONE   = 3'd2,
		EV_CANCEL = 3'd3,
		EV_REJECT = 3'd4
	} event_t;

	typedef struct packed {
		logic [1:0]                      mode;
		logic signed [POSITION_BITS-1:0] position;
	} in_item_t;

	typedef struct packed {
		logic signed [DRIVE_BITS-1:0]    drive;
		logic [1:0]                      phase;
		logic [2:0]                      event_res;
		logic signed [POSITION_BITS-1:0] stop_angle;
	} out_item_t;

	typedef struct packed {
		logic [15:0]           check_interval_ticks;
		logic [14:0]           move_threshold;
		logic [7:0]            stall_checks;
		logic [14:0]           travel_distance;
		logic [LEVEL_BITS-1:0] drive_level;
	} cfg_t;

endpackage

`default_nettype wire

// File: design/sdhs_core.sv
`default_nettype none

module sdhs_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire sdhs_pkg::in_item_t item,
	input  wire sdhs_pkg::cfg_t     cfg,
	output sdhs_pkg::out_item_t     result
);
	import sdhs_pkg::*;

	localparam int unsigned PW = POSITION_BITS;

	// Largest signed position, the saturation point of the retract target.
	localparam logic signed [PW:0] POS_MAX = (PW+1)'((1 << (PW-1)) - 1);

	phase_t               phase_q, phase_n;
	logic [15:0]          tick_q, tick_n;
	logic signed [PW-1:0] prev_q, prev_n;
	logic                 flag_q, flag_n;
	logic [7:0]           count_q, count_n;
	logic signed [PW-1:0] target_q, target_n;
	logic signed [PW-1:0] offset_q, offset_n;
	event_t               ev;

	logic [15:0]          tick_inc;
	logic signed [PW:0]   delta;
	logic [PW:0]          change;
	logic [7:0]           count_inc;
	logic signed [PW:0]   target_sum;
	logic [LEVEL_BITS-1:0] level;

	// Datapath pieces shared by the tick handling.
	always_comb begin
		tick_inc   = tick_q + 16'd1;
		delta      = {item.position[PW-1], item.position} - {prev_q[PW-1], prev_q};
		change     = delta[PW] ? (PW+1)'(-delta) : (PW+1)'(delta);
		count_inc  = (count_q != 8'hFF) ? count_q + 8'd1 : count_q;
		target_sum = {item.position[PW-1], item.position}
			+ $signed({2'b00, cfg.travel_distance});
	end

	// Next state of the sequencer for the item in the input stage.
	always_comb begin
		phase_n  = phase_q;
		tick_n   = tick_q;
		prev_n   = prev_q;
		flag_n   = flag_q;
		count_n  = count_q;
		target_n = target_q;
		offset_n = offset_q;
		ev       = EV_NONE;
		case (mode_t'(item.mode))
			MODE_TICK: begin
				if (phase_q == PH_EXTEND) begin
					tick_n = tick_inc;
					if (tick_inc >= cfg.check_interval_ticks) begin
						tick_n = '0;
						prev_n = item.position;
						if (change < (PW+1)'(cfg.move_threshold)) begin
							if (!flag_q) begin
								flag_n  = 1'b1;
								count_n = '0;
							end else begin
								count_n = count_inc;
								if (count_inc >= cfg.stall_checks) begin
									offset_n = item.position;
									target_n = (target_sum > POS_MAX) ?
										PW'(POS_MAX) : PW'(target_sum);
									phase_n  = PH_RETRACT;
									flag_n   = 1'b0;
									count_n  = '0;
									ev       = EV_FOUND;
								end
							end
						end else begin
							flag_n  = 1'b0;
							count_n = '0;
						end
					end
				end else if (phase_q == PH_RETRACT) begin
					if (item.position >= target_q) begin
						phase_n = PH_IDLE;
						ev      = EV_DONE;
					end
				end
			end
			MODE_START: begin
				if (phase_q == PH_IDLE) begin
					phase_n = PH_EXTEND;
					prev_n  = item.position;
					tick_n  = '0;
					flag_n  = 1'b0;
					count_n = '0;
				end else begin
					ev = EV_REJECT;
				end
			end
			MODE_CANCEL: begin
				if (phase_q != PH_IDLE) begin
					phase_n = PH_IDLE;
					tick_n  = '0;
					flag_n  = 1'b0;
					count_n = '0;
					ev      = EV_CANCEL;
				end
			end
			default: begin
			end
		endcase
	end

	// Result fields follow the phase after the event.
	always_comb begin
		level = (cfg.drive_level > LEVEL_MAX) ? LEVEL_MAX : cfg.drive_level;
		case (phase_n)
			PH_EXTEND:  result.drive = -$signed({1'b0, level});
			PH_RETRACT: result.drive = $signed({1'b0, level});
			default:    result.drive = '0;
		endcase
		result.phase       = phase_n;
		result.event_res   = ev;
		result.stop_angle  = offset_n;
	end

	// Sequencer state, updated when the item leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			tick_q   <= '0;
			prev_q   <= '0;
			flag_q   <= 1'b0;
			count_q  <= '0;
			target_q <= '0;
			offset_q <= '0;
		end else if (fire) begin
			phase_q  <= phase_n;
			tick_q   <= tick_n;
			prev_q   <= prev_n;
			flag_q   <= flag_n;
			count_q  <= count_n;
			target_q <= target_n;
			offset_q <= offset_n;
		end
	end

endmodule

`default_nettype wire

// File: design/stall_detect_homing_sequencer_unit.sv
// Sensorless stall homing sequencer.
// The in channel carries events: a tick with an encoder angle, a start
// (with the starting angle) or a cancel. The out channel returns exactly one
// result per event: drive duty, phase, event code and the latched home offset.
// Both channels transfer on valid and ready high at a rising clock edge.
// An event is registered in an input stage, evaluated combinationally by the
// sequencer and written to the output register, from which it transfers on
// the out channel; one event per cycle is sustained while out_ready is high.
// When the receiver stalls, the output register holds its result, the input
// stage holds the next event, and in_ready is low while both are occupied
// and out_ready is low; sequencer state advances only when an event moves to
// the output register.
// Configuration writes on cfg_wr_en take effect at once and are to be made
// while no event is in flight. Reset clears the sequencer to idle with a
// zero home offset and loads the default configuration.
`default_nettype none

module stall_detect_homing_sequencer_unit (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire sdhs_pkg::in_item_t                     in_data,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output sdhs_pkg::out_item_t                         out_data,
	input  wire logic                                   cfg_wr_en,
	input  wire logic [sdhs_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  wire logic [sdhs_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);
	import sdhs_pkg::*;

	cfg_t      cfg_q;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      advance;
	out_item_t result;
	logic      out_valid_q;
	out_item_t out_q;

	// The input stage moves on when the output register is free or draining.
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.check_interval_ticks <= 16'd100;
			cfg_q.move_threshold       <= 15'd82;
			cfg_q.stall_checks         <= 8'd30;
			cfg_q.travel_distance      <= 15'd3217;
			cfg_q.drive_level          <= LEVEL_MAX;
		end else if (cfg_wr_en) begin
			case (reg_index_t'(cfg_index))
				REG_CHECK_INTERVAL: cfg_q.check_interval_ticks <= cfg_wdata;
				REG_POS_THRESHOLD:  cfg_q.move_threshold       <= cfg_wdata[14:0];
				REG_STALL_CHECKS:   cfg_q.stall_checks         <= cfg_wdata[7:0];
				REG_TRAVEL:         cfg_q.travel_distance      <= cfg_wdata[14:0];
				REG_DRIVE_LEVEL:    cfg_q.drive_level          <= cfg_wdata[LEVEL_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	sdhs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

endmodule

`default_nettype wire
